// ===== sv/lrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_pkg: shared types and constants of the route table
// Command and status codes, the request and response transfer types, the
// stored route record and the controller state encoding.
// ----------------------------------------------------------------------------
package lrt_pkg;

	localparam int ADDR_BITS = 32;
	localparam logic [5:0] MAX_LEN = 6'd32;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_BAD_LEN   = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] address;
		logic [5:0]  prefix_len;
		logic [15:0] if_index;
		logic [31:0] next_hop;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_if_index;
		logic [31:0] out_next_hop;
		logic [5:0]  out_prefix_len;
	} rsp_t;

	typedef struct packed {
		logic [31:0] prefix;
		logic [5:0]  length;
		logic [15:0] intf;
		logic [31:0] hop;
	} entry_t;

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		SHIFT
	} state_t;

endpackage

// ===== sv/lrt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/lpm_route_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_route_table: IPv4 longest-prefix-match route table
// Routes are kept oldest first in one RAM; lookup and delete scan the used part.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low; req carries the
// command, prefix or destination address, length, interface and next hop.
// Exactly one response per command appears on rsp, marked by a one-cycle
// done; the receiver cannot stall it, so it must take it in that cycle.
// A valid insert writes the next free RAM entry in the transfer cycle; every
// insert responds in the following cycle and busy stays low.
// Lookup reads every stored route once through the single RAM read port and
// keeps the longest match before it responds.
// Delete makes the same scan to find the newest equal route at slot p, then
// moves every later route down by one, reading slot i + 1 and writing slot i
// in the following cycle.
// Busy falls in the cycle of the response, so the next command can be taken
// in that same cycle.
// Reset clears the route count; RAM contents need no clearing since only
// slots below the count are ever read.
// ----------------------------------------------------------------------------
module lpm_route_table #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lrt_pkg::req_t req,
	output logic          done,
	output lrt_pkg::rsp_t rsp
);

	import lrt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ip_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic [1:0]    op_q;
	logic [31:0]   addr_q;
	logic [5:0]    len_q;
	logic [5:0]    best_len_q;
	logic [15:0]   best_if_q;
	logic [31:0]   best_hop_q;
	logic          found_q;
	logic [AW-1:0] pos_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic          accept;
	logic          ins_ok;
	logic          issue;
	logic          scan_end;
	logic          hit_lookup;
	logic          hit_delete;
	logic [31:0]   mask;
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	entry_t        rdata;
	logic [$bits(entry_t)-1:0] rdata_raw;
	rsp_t          rsp_d;
	logic          rsp_ld;

	assign accept = start && !busy;
	assign busy   = (state_q != IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign rdata  = entry_t'(rdata_raw);

	lrt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(ip_q[AW-1:0]),
		.rdata(rdata_raw)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (accept && (req.cmd == CMD_LOOKUP || req.cmd == CMD_DELETE)) begin
					state_d = SCAN;
				end
			end
			SCAN: begin
				if (scan_end) begin
					state_d = (op_q == CMD_DELETE && found_q) ? SHIFT : IDLE;
				end
			end
			SHIFT: begin
				if (scan_end) begin
					state_d = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_comb begin
		ins_ok     = accept && req.cmd == CMD_INSERT && req.prefix_len <= MAX_LEN
			&& cnt_q < DEPTH_C;
		issue      = (state_q == SCAN || state_q == SHIFT) && ip_q < cnt_q;
		scan_end   = (ip_q == cnt_q) && !vld_s1;
		mask       = ~({ADDR_BITS{1'b1}} >> rdata.length);
		hit_lookup = state_q == SCAN && vld_s1 && op_q == CMD_LOOKUP
			&& rdata.length != 6'd0 && ((rdata.prefix ^ addr_q) & mask) == 32'd0
			&& rdata.length >= best_len_q;
		hit_delete = state_q == SCAN && vld_s1 && op_q == CMD_DELETE
			&& rdata.prefix == addr_q && rdata.length == len_q;
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = '{prefix: req.address, length: req.prefix_len,
			intf: req.if_index, hop: req.next_hop};
		if (state_q == SHIFT && vld_s1) begin
			we    = 1'b1;
			waddr = idx_s1 - AW'(1);
			wdata = rdata;
		end else if (ins_ok) begin
			we = 1'b1;
		end
	end

	always_comb begin
		rsp_ld       = 1'b0;
		rsp_d        = '0;
		rsp_d.status = STAT_NOT_FOUND;
		if (accept && req.cmd == CMD_INSERT) begin
			rsp_ld = 1'b1;
			if (req.prefix_len > MAX_LEN) begin
				rsp_d.status = STAT_BAD_LEN;
			end else if (cnt_q >= DEPTH_C) begin
				rsp_d.status = STAT_FULL;
			end else begin
				rsp_d.status = STAT_OK;
			end
		end else if (accept && req.cmd != CMD_LOOKUP && req.cmd != CMD_DELETE) begin
			rsp_ld = 1'b1;
		end else if (state_q == SCAN && scan_end) begin
			rsp_ld = 1'b1;
			if (op_q == CMD_LOOKUP && best_len_q != 6'd0) begin
				rsp_d.status         = STAT_OK;
				rsp_d.out_if_index   = best_if_q;
				rsp_d.out_next_hop   = best_hop_q;
				rsp_d.out_prefix_len = best_len_q;
			end
		end else if (state_q == SHIFT && scan_end) begin
			rsp_ld       = 1'b1;
			rsp_d.status = STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
			ip_q    <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (ins_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == SHIFT && scan_end) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (accept) begin
				ip_q    <= '0;
				found_q <= 1'b0;
			end else if (state_q == SCAN && state_d == SHIFT) begin
				ip_q <= CW'(pos_q) + CW'(1);
			end else if (issue) begin
				ip_q <= ip_q + CW'(1);
			end
			if (hit_delete) begin
				found_q <= 1'b1;
			end
			done_q <= (accept && req.cmd != CMD_LOOKUP && req.cmd != CMD_DELETE)
				|| (state_q != IDLE && state_d == IDLE);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ip_q[AW-1:0];
		if (accept) begin
			op_q       <= req.cmd;
			addr_q     <= req.address;
			len_q      <= req.prefix_len;
			best_len_q <= 6'd0;
			best_if_q  <= 16'd0;
			best_hop_q <= 32'd0;
		end
		if (hit_lookup) begin
			best_len_q <= rdata.length;
			best_if_q  <= rdata.intf;
			best_hop_q <= rdata.hop;
		end
		if (hit_delete) begin
			pos_q <= idx_s1;
		end
		if (rsp_ld) begin
			rsp_q <= rsp_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("route count exceeds table depth");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SHIFT && vld_s1) |-> (CW'(idx_s1) < cnt_q && idx_s1 != '0))
		else $error("shift touches a slot outside the stored routes");

	a_done_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan finished without a response");

	a_insert_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.cmd == CMD_INSERT) |=> (done && !busy))
		else $error("insert did not respond in one cycle");

	a_no_start_scan_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SCAN && cnt_q == '0) |-> !vld_s1)
		else $error("read issued on an empty table");

endmodule

// ===== test/lpm_route_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_route_table_tb: self-checking testbench of the IPv4 route table
// A directed run covers the edge cases of insert, lookup and delete. Random
// command mixes then fill the table to full and drain it again, with
// most lookups and deletes aimed at stored routes. A scoreboard keeps its own
// copy of the table and checks every response in order.
// ----------------------------------------------------------------------------
module lpm_route_table_tb;

	import lrt_pkg::*;

	localparam int DEPTH = 32;
	localparam int RANDOM_ITEMS = 826;
	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT = 2000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	class lpm_scoreboard;
		logic [31:0] route_prefix [DEPTH];
		logic [5:0]  route_len    [DEPTH];
		logic [15:0] route_intf   [DEPTH];
		logic [31:0] route_hop    [DEPTH];
		int          route_count;
		rsp_t        pending_replies [$];
		int          mismatches;

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%t: %s", $realtime, msg);
			end
		endfunction

		function void note_command(req_t r);
			rsp_t        exp;
			int          hit;
			logic [31:0] mask;
			exp = '0;
			exp.status = STAT_NOT_FOUND;
			case (r.cmd)
				CMD_INSERT: begin
					if (r.prefix_len > MAX_LEN) begin
						exp.status = STAT_BAD_LEN;
					end else if (route_count >= DEPTH) begin
						exp.status = STAT_FULL;
					end else begin
						route_prefix[route_count] = r.address;
						route_len[route_count] = r.prefix_len;
						route_intf[route_count] = r.if_index;
						route_hop[route_count] = r.next_hop;
						route_count++;
						exp.status = STAT_OK;
					end
				end
				CMD_LOOKUP: begin
					for (int k = route_count - 1; k >= 0; k--) begin
						if (route_len[k] != 0 && route_len[k] <= MAX_LEN) begin
							mask = 32'hFFFF_FFFF << (ADDR_BITS - route_len[k]);
							if (((route_prefix[k] ^ r.address) & mask) == 0 &&
									route_len[k] > exp.out_prefix_len) begin
								exp.status = STAT_OK;
								exp.out_prefix_len = route_len[k];
								exp.out_if_index = route_intf[k];
								exp.out_next_hop = route_hop[k];
							end
						end
					end
				end
				CMD_DELETE: begin
					hit = -1;
					for (int k = route_count - 1; k >= 0 && hit < 0; k--) begin
						if (route_prefix[k] == r.address && route_len[k] == r.prefix_len) begin
							hit = k;
						end
					end
					if (hit >= 0) begin
						for (int i = hit; i + 1 < route_count; i++) begin
							route_prefix[i] = route_prefix[i + 1];
							route_len[i] = route_len[i + 1];
							route_intf[i] = route_intf[i + 1];
							route_hop[i] = route_hop[i + 1];
						end
						route_count--;
						exp.status = STAT_OK;
					end
				end
				default: begin
				end
			endcase
			pending_replies.push_back(exp);
		endfunction

		function void check_reply(rsp_t got);
			rsp_t exp;
			if (pending_replies.size() == 0) begin
				flag($sformatf("Response with none expected: status %0d if %h hop %h len %0d",
					got.status, got.out_if_index, got.out_next_hop, got.out_prefix_len));
			end else begin
				exp = pending_replies.pop_front();
				if (got.status !== exp.status || got.out_if_index !== exp.out_if_index ||
						got.out_next_hop !== exp.out_next_hop ||
						got.out_prefix_len !== exp.out_prefix_len) begin
					flag($sformatf({"Mismatch: expected status %0d if %h hop %h len %0d, ",
						"got status %0d if %h hop %h len %0d"},
						exp.status, exp.out_if_index, exp.out_next_hop, exp.out_prefix_len,
						got.status, got.out_if_index, got.out_next_hop, got.out_prefix_len));
				end
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	req_t          req = '0;
	logic          done;
	rsp_t          rsp;
	lpm_scoreboard sb;
	bit            idle_on = 1'b1;
	int            stall_cycles = 0;

	lpm_route_table #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic req_t build_req(logic [1:0] cmd, logic [31:0] addr, logic [5:0] plen,
			logic [15:0] ifx, logic [31:0] hop);
		req_t r;
		r.cmd = cmd;
		r.address = addr;
		r.prefix_len = plen;
		r.if_index = ifx;
		r.next_hop = hop;
		return r;
	endfunction

	// Most addresses share their top bits so that routes nest and overlap.
	function automatic logic [31:0] cluster_address();
		logic [31:0] addr;
		addr = $urandom();
		if ($urandom_range(0, 99) < 75) begin
			addr[31:14] = {16'hC0A8, 2'($urandom_range(0, 3))};
		end
		return addr;
	endfunction

	function automatic req_t random_command(int mix);
		req_t        r;
		int          roll;
		int          k;
		int          ins_pct;
		int          del_pct;
		logic [31:0] mask;
		r = build_req(CMD_LOOKUP, $urandom(), 6'($urandom()), 16'($urandom()), $urandom());
		ins_pct = (mix == 0) ? 65 : (mix == 1) ? 35 : 15;
		del_pct = (mix == 0) ? 8 : (mix == 1) ? 25 : 50;
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			r.cmd = CMD_UNUSED;
		end else if (roll < 2 + ins_pct) begin
			r.cmd = CMD_INSERT;
			r.address = cluster_address();
			roll = $urandom_range(0, 99);
			if (roll < 7) begin
				r.prefix_len = 6'($urandom_range(33, 63));
			end else if (roll < 12) begin
				r.prefix_len = '0;
			end else if (roll < 20) begin
				r.prefix_len = MAX_LEN;
			end else begin
				r.prefix_len = 6'($urandom_range(1, 31));
			end
		end else if (roll < 2 + ins_pct + del_pct) begin
			r.cmd = CMD_DELETE;
			roll = $urandom_range(0, 99);
			if (sb.route_count > 0 && roll < 80) begin
				k = $urandom_range(0, sb.route_count - 1);
				r.address = sb.route_prefix[k];
				r.prefix_len = sb.route_len[k];
				if (roll >= 70) begin
					r.prefix_len[0] = ~r.prefix_len[0];
				end
			end
		end else begin
			if (sb.route_count > 0 && $urandom_range(0, 99) < 70) begin
				k = $urandom_range(0, sb.route_count - 1);
				mask = (sb.route_len[k] == 0) ? '0 :
					32'hFFFF_FFFF << (ADDR_BITS - sb.route_len[k]);
				r.address = (sb.route_prefix[k] & mask) | ($urandom() & ~mask);
			end else begin
				r.address = cluster_address();
			end
		end
		return r;
	endfunction

	task automatic issue(req_t r);
		int gap;
		if (idle_on && $urandom_range(0, 99) < 17) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 5);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		sb.note_command(r);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				sb.check_reply(rsp);
			end
			if ((start && !busy) || done) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(build_req(CMD_LOOKUP, 32'hC0A8_0101, 6'd24, 16'h1234, 32'h0));
		issue(build_req(CMD_DELETE, 32'h0, 6'd0, 16'h0, 32'h0));
		issue(build_req(CMD_UNUSED, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 32'hFFFF_FFFF));
		issue(build_req(CMD_INSERT, 32'h0A00_0000, 6'd33, 16'h0001, 32'h0A00_0001));
		issue(build_req(CMD_INSERT, 32'h0A00_0000, 6'd63, 16'h0001, 32'h0A00_0001));
		issue(build_req(CMD_INSERT, 32'h0, 6'd0, 16'h0007, 32'h0101_0101));
		issue(build_req(CMD_LOOKUP, 32'h0, 6'd0, 16'h0, 32'h0));
		issue(build_req(CMD_INSERT, 32'hC0A8_0100, 6'd24, 16'h0001, 32'hC0A8_01FE));
		issue(build_req(CMD_INSERT, 32'hC0A8_0000, 6'd16, 16'h0002, 32'hC0A8_00FE));
		issue(build_req(CMD_INSERT, 32'hC0A8_0101, 6'd32, 16'h0003, 32'hC0A8_0102));
		issue(build_req(CMD_INSERT, 32'hC0A8_0100, 6'd24, 16'h0004, 32'hC0A8_01FD));
		issue(build_req(CMD_LOOKUP, 32'hC0A8_0105, 6'd0, 16'h0, 32'h0));
		issue(build_req(CMD_LOOKUP, 32'hC0A8_0101, 6'd0, 16'h0, 32'h0));
		issue(build_req(CMD_LOOKUP, 32'hC0A8_FF00, 6'd0, 16'h0, 32'h0));
		issue(build_req(CMD_LOOKUP, 32'h7FFF_FFFF, 6'd0, 16'h0, 32'h0));
		issue(build_req(CMD_INSERT, 32'hFFFF_FFFF, 6'd1, 16'hFFFF, 32'hFFFF_FFFF));
		issue(build_req(CMD_LOOKUP, 32'h8000_0000, 6'd0, 16'h0, 32'h0));
		issue(build_req(CMD_DELETE, 32'hC0A8_0100, 6'd24, 16'h0, 32'h0));
		issue(build_req(CMD_LOOKUP, 32'hC0A8_0105, 6'd0, 16'h0, 32'h0));
		issue(build_req(CMD_DELETE, 32'hC0A8_0100, 6'd25, 16'h0, 32'h0));
		issue(build_req(CMD_DELETE, 32'hC0A8_0100, 6'd40, 16'h0, 32'h0));
		issue(build_req(CMD_DELETE, 32'h0, 6'd0, 16'h0, 32'h0));
		issue(build_req(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 32'hFFFF_FFFF));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_on = !(i >= 300 && i < 450);
			issue(random_command((i / 120) % 3));
		end
		start <= 1'b0;

		while (sb.pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_replies.size() != 0) begin
			sb.flag($sformatf("%0d responses never arrived", sb.pending_replies.size()));
		end
		if (sb.mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
